FILE: rtl/cht_pkg.sv
package cht_pkg;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned CMP_W   = 4;
  localparam int unsigned TOTAL_W = 11;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic [CMP_W-1:0]   CMP_MAX       = 4'd15;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX     = 11'd2047;
  localparam logic [CFG_W-1:0]   TABLE_SIZE_RST = 8'd128;

  typedef struct packed {
    logic             func;
    logic [KEY_W-1:0] key;
  } cht_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CMP_W-1:0]   comparisons;
    logic [TOTAL_W-1:0] element_count;
  } cht_out_t;

endpackage

FILE: rtl/cht_ram.sv
module cht_ram
  import cht_pkg::*;
#(
  parameter int unsigned WIDTH     = 8,
  parameter int unsigned NUM_WORDS = 16,
  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [NUM_WORDS];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cht_mod_unit.sv
module cht_mod_unit
  import cht_pkg::*;
#(
  parameter int unsigned SW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] dividend_i,
  input  logic [SW-1:0]    divisor_i,
  output logic             done_o,
  output logic [SW-1:0]    rem_o
);

  localparam int unsigned CW = $clog2(KEY_W);

  logic             busy_q, busy_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [KEY_W-1:0] dvd_q, dvd_d;
  logic [SW-1:0]    rem_q, rem_d;
  logic [SW:0]      trial;
  logic [SW:0]      diff;
  logic             ge;

  assign trial = {rem_q, dvd_q[KEY_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(KEY_W - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[KEY_W-2:0], 1'b0};
      rem_d = ge ? diff[SW-1:0] : trial[SW-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign rem_o  = rem_q;

endmodule

FILE: rtl/chained_hash_table_core.sv
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_data_i  (func, key)
// out      output     out_valid_o / out_stall_i out_data_o (status, comparisons, element_count)
// cfg      input      cfg_we_i                 cfg_wdata_i (table_size)
//
// After acceptance the 31-step bit-serial modulo unit picks the bucket, its fill counter is read,
// and the keys in the bucket, at most DEPTH of them, are compared one by one through the single
// read port of the key memory.
// After reset a clearing pass writes zero to every fill counter, during which in_stall_o
// stays high.
// The result register frees the engine: a new transaction may be accepted while the
// previous result is still stalled, and the engine waits only to hand over its next one.
module chained_hash_table_core
  import cht_pkg::*;
#(
  parameter int unsigned BUCKETS = 128,
  parameter int unsigned DEPTH   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cht_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cht_out_t         out_data_o
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned SW = $clog2(BUCKETS + 1);
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned NK = BUCKETS * DEPTH;
  localparam int unsigned AW = (NK > 1) ? $clog2(NK) : 1;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DIV      = 3'd2;
  localparam logic [2:0] S_FILL_RD  = 3'd3;
  localparam logic [2:0] S_FILL_GET = 3'd4;
  localparam logic [2:0] S_SCAN     = 3'd5;
  localparam logic [2:0] S_CMP      = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [CFG_W-1:0]   table_size_q;
  logic [SW-1:0]      size_eff;
  logic [BW-1:0]      clr_q, clr_d;
  logic               func_q, func_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [BW-1:0]      bucket_q, bucket_d;
  logic [AW-1:0]      base_q, base_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [FW-1:0]      idx_q, idx_d;
  logic               hit_q, hit_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               out_valid_q, out_valid_d;
  cht_out_t           out_q, out_d;

  logic               accept;
  logic               div_done;
  logic [SW-1:0]      div_rem;
  logic               fill_we;
  logic [BW-1:0]      fill_waddr;
  logic [FW-1:0]      fill_wdata;
  logic [FW-1:0]      fill_rdata;
  logic               key_we;
  logic [AW-1:0]      key_waddr;
  logic [AW-1:0]      key_raddr;
  logic [KEY_W-1:0]   key_rdata;
  logic               result_go;
  logic [FW:0]        cmp_raw;
  logic [CMP_W-1:0]   cmp_sat;
  logic               bucket_full;

  always_comb begin
    if (table_size_q == '0) begin
      size_eff = SW'(1);
    end else if (32'(table_size_q) > BUCKETS) begin
      size_eff = SW'(BUCKETS);
    end else begin
      size_eff = SW'(table_size_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RST;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  assign accept = (state_q == S_IDLE) && in_valid_i;

  cht_mod_unit #(
    .SW(SW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .dividend_i(in_data_i.key),
    .divisor_i (size_eff),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  assign result_go   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign bucket_full = fill_q == FW'(DEPTH);
  assign cmp_raw     = hit_q ? ({1'b0, idx_q} + 1'b1) : {1'b0, idx_q};
  assign cmp_sat     = (32'(cmp_raw) > 32'(CMP_MAX)) ? CMP_MAX : CMP_W'(cmp_raw);

  assign key_we     = result_go && (func_q == FUNC_INSERT) && !hit_q && !bucket_full;
  assign key_waddr  = base_q + AW'(fill_q);
  assign key_raddr  = base_q + AW'(idx_q);
  assign fill_we    = (state_q == S_CLEAR) || key_we;
  assign fill_waddr = (state_q == S_CLEAR) ? clr_q : bucket_q;
  assign fill_wdata = (state_q == S_CLEAR) ? '0 : fill_q + 1'b1;

  cht_ram #(
    .WIDTH    (FW),
    .NUM_WORDS(BUCKETS)
  ) u_fill_ram (
    .clk_i  (clk_i),
    .we_i   (fill_we),
    .waddr_i(fill_waddr),
    .wdata_i(fill_wdata),
    .raddr_i(bucket_d),
    .rdata_o(fill_rdata)
  );

  cht_ram #(
    .WIDTH    (KEY_W),
    .NUM_WORDS(NK)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_q),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    func_d      = func_q;
    key_d       = key_q;
    bucket_d    = bucket_q;
    base_d      = base_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == BUCKETS - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          func_d  = in_data_i.func;
          key_d   = in_data_i.key;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_FILL_RD;
        end
      end
      S_FILL_RD: begin
        bucket_d = div_rem[BW-1:0];
        state_d  = S_FILL_GET;
      end
      S_FILL_GET: begin
        base_d  = AW'(bucket_q) * AW'(DEPTH);
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (idx_q == fill_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (key_rdata == key_q) begin
          hit_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SCAN;
        end
      end
      S_DONE: begin
        if (result_go) begin
          if (key_we && (total_q != TOTAL_MAX)) begin
            total_d = total_q + 1'b1;
          end
          if (func_q == FUNC_INSERT) begin
            out_d.comparisons = '0;
            if (hit_q) begin
              out_d.status = ST_DUPLICATE;
            end else if (bucket_full) begin
              out_d.status = ST_FULL;
            end else begin
              out_d.status = ST_INSERTED;
            end
          end else begin
            out_d.comparisons = cmp_sat;
            out_d.status      = hit_q ? ST_FOUND : ST_NOT_FOUND;
          end
          out_d.element_count = total_d;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (state_q == S_FILL_GET) begin
      fill_d = fill_rdata;
      idx_d  = '0;
      hit_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    key_q    <= key_d;
    bucket_q <= bucket_d;
    base_q   <= base_d;
    fill_q   <= fill_d;
    idx_q    <= idx_d;
    hit_q    <= hit_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/cht_checker.sv
module cht_checker
  import cht_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input cht_out_t         out_data_o
);

  // A result still waiting must stay offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // The engine works on one transaction at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_INSERTED || out_data_o.status == ST_DUPLICATE ||
                    out_data_o.status == ST_FULL) |-> out_data_o.comparisons == '0)
    else $error("insert reported comparisons");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_NOT_FOUND |-> !$isunknown(out_data_o.comparisons))
    else $error("unknown comparison count on a miss");

endmodule

bind chained_hash_table_core cht_checker u_cht_checker (.*);
